// File: hdl/sfhc_pkg.sv
// shared types, constants and the crc byte update of the frame header checker
package sfhc_pkg;

	localparam int HEADER_BYTES = 10;
	localparam int TAG_BYTES    = 16;
	localparam int BLOCK_BYTES  = 16;

	localparam int POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// header byte offsets
	localparam logic [POS_W-1:0] POS_MAGIC0  = 17'd0;
	localparam logic [POS_W-1:0] POS_MAGIC1  = 17'd1;
	localparam logic [POS_W-1:0] POS_CMD_HI  = 17'd2;
	localparam logic [POS_W-1:0] POS_CMD_LO  = 17'd3;
	localparam logic [POS_W-1:0] POS_TID_HI  = 17'd4;
	localparam logic [POS_W-1:0] POS_TID_LO  = 17'd5;
	localparam logic [POS_W-1:0] POS_CRC_HI  = 17'd6;
	localparam logic [POS_W-1:0] POS_CRC_LO  = 17'd7;
	localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd8;
	localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd9;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_MAGIC0 = 2'd1;
	localparam logic [1:0] REG_MAGIC1 = 2'd2;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_MAGIC  = 3'd2,
		ST_LENGTH = 3'd3,
		ST_CRC    = 3'd4
	} status_t;

	typedef struct packed {
		logic       frame_mode;
		logic [7:0] magic_first;
		logic [7:0] magic_second;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] command;
		logic [15:0] transaction_id;
		logic [15:0] payload_length;
	} res_t;

	// reflected crc-16 update over one byte, eight bit steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: hdl/secure_frame_header_crc_checker.sv
// top level of the streaming frame header and crc-16 checker
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = byte_value, s_tlast = frame_last
//  m_*       out  m_tvalid/m_tready  m_tdata = status, command, transaction_id, length
//  apb       in   psel/penable       mode, magic bytes at 0x0, 0x4, 0x8
//
// one byte per cycle while s_tready is high; the status of a frame is registered
// and shows on m_* the cycle after its last byte
// arst_n clears the frame state, the config registers and the result valid flag
// a stalled result holds m_* and blocks s_* only while the result register is full
module secure_frame_header_crc_checker #(
	parameter int TAG_BYTES = sfhc_pkg::TAG_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tlast,   // frame_last
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [2:0] status, [18:3] command,
	                               // [34:19] transaction_id, [50:35] payload_length
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sfhc_pkg::cfg_t cfg_q;
	sfhc_pkg::res_t res_next, res_hold;
	logic           in_accept;
	logic           cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign in_accept = s_tvalid && s_tready;

	// register write, word index from paddr, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				sfhc_pkg::REG_MODE:   cfg_q.frame_mode   <= pwdata[0];
				sfhc_pkg::REG_MAGIC0: cfg_q.magic_first  <= pwdata[7:0];
				sfhc_pkg::REG_MAGIC1: cfg_q.magic_second <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			sfhc_pkg::REG_MODE:   prdata = {31'd0, cfg_q.frame_mode};
			sfhc_pkg::REG_MAGIC0: prdata = {24'd0, cfg_q.magic_first};
			sfhc_pkg::REG_MAGIC1: prdata = {24'd0, cfg_q.magic_second};
			default:              prdata = 32'd0;
		endcase
	end

	// header capture and crc, one byte per transfer
	sfhc_frame #(
		.TAG_BYTES (TAG_BYTES)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (in_accept),
		.byte_value (s_tdata),
		.frame_last (s_tlast),
		.res        (res_next)
	);

	// result register, loaded on the last byte of a frame
	sfhc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_accept && s_tlast),
		.res_in    (res_next),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.in_ready  (s_tready),
		.res_out   (res_hold)
	);

	assign m_tdata = {5'd0, res_hold.payload_length, res_hold.transaction_id,
		res_hold.command, res_hold.status};

	// input side only stalls while a result waits
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// a frame end always produces a result
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> m_tvalid)
		else $error("no result after frame end");

	// a byte inside a frame never produces a result
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tlast && (!m_tvalid || m_tready)) |=> !m_tvalid)
		else $error("result without frame end");

	// status code within the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= 3'(sfhc_pkg::ST_CRC)))
		else $error("undefined status code");

endmodule

// File: hdl/sfhc_frame.sv
// per-frame header capture, crc accumulation and status decision
module sfhc_frame #(
	parameter int TAG_BYTES = sfhc_pkg::TAG_BYTES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sfhc_pkg::cfg_t cfg,
	input  logic           accept,
	input  logic [7:0]     byte_value,
	input  logic           frame_last,
	output sfhc_pkg::res_t res
);

	logic [sfhc_pkg::POS_W-1:0] pos_q, pos_d;
	logic        magic_ok_q, magic_ok_d;
	logic [15:0] cmd_q, cmd_d;
	logic [15:0] tid_q, tid_d;
	logic [15:0] rcrc_q, rcrc_d;
	logic [15:0] len_q, len_d;
	logic [15:0] crc_q, crc_d;

	logic [15:0] ct_len_cur, ct_len_d;
	logic [sfhc_pkg::POS_W-1:0] ct_off;
	logic [sfhc_pkg::POS_W:0]   total, need;
	logic        len_small;

	always_comb begin
		pos_d      = pos_q;
		magic_ok_d = magic_ok_q;
		cmd_d      = cmd_q;
		tid_d      = tid_q;
		rcrc_d     = rcrc_q;
		len_d      = len_q;
		crc_d      = crc_q;
		ct_len_cur = (len_q >= 16'(sfhc_pkg::HEADER_BYTES)) ?
			len_q - 16'(sfhc_pkg::HEADER_BYTES) : 16'd0;
		ct_off     = pos_q - sfhc_pkg::POS_W'(sfhc_pkg::HEADER_BYTES);
		unique case (pos_q)
			sfhc_pkg::POS_MAGIC0: if (byte_value != cfg.magic_first) magic_ok_d = 1'b0;
			sfhc_pkg::POS_MAGIC1: if (byte_value != cfg.magic_second) magic_ok_d = 1'b0;
			sfhc_pkg::POS_CMD_HI: cmd_d[15:8]  = byte_value;
			sfhc_pkg::POS_CMD_LO: cmd_d[7:0]   = byte_value;
			sfhc_pkg::POS_TID_HI: tid_d[15:8]  = byte_value;
			sfhc_pkg::POS_TID_LO: tid_d[7:0]   = byte_value;
			sfhc_pkg::POS_CRC_HI: rcrc_d[15:8] = byte_value;
			sfhc_pkg::POS_CRC_LO: rcrc_d[7:0]  = byte_value;
			sfhc_pkg::POS_LEN_HI: len_d[15:8]  = byte_value;
			sfhc_pkg::POS_LEN_LO: len_d[7:0]   = byte_value;
			default: begin
				if (pos_q >= sfhc_pkg::POS_W'(sfhc_pkg::HEADER_BYTES) &&
				    ct_off < {1'b0, ct_len_cur}) begin
					crc_d = sfhc_pkg::crc_byte(crc_q, byte_value);
				end
			end
		endcase
		if (pos_q != sfhc_pkg::POS_MAX) begin
			pos_d = pos_q + 1'b1;
		end
	end

	// status from the state as it stands after this byte
	always_comb begin
		len_small = len_d < 16'(sfhc_pkg::HEADER_BYTES);
		ct_len_d  = len_small ? 16'd0 : len_d - 16'(sfhc_pkg::HEADER_BYTES);
		total     = {1'b0, pos_q} + 1'b1;
		need      = 18'(sfhc_pkg::HEADER_BYTES) + {2'b00, ct_len_d} +
			(cfg.frame_mode ? 18'd0 : 18'(TAG_BYTES));
		res.command        = cmd_d;
		res.transaction_id = tid_d;
		res.payload_length = ct_len_d;
		if (total < 18'(sfhc_pkg::HEADER_BYTES)) begin
			res.status = sfhc_pkg::ST_SHORT;
		end else if (!magic_ok_d) begin
			res.status = sfhc_pkg::ST_MAGIC;
		end else if (len_small) begin
			res.status = sfhc_pkg::ST_LENGTH;
		end else if (cfg.frame_mode && (ct_len_d == 16'd0 ||
		             (ct_len_d & 16'(sfhc_pkg::BLOCK_BYTES - 1)) != 16'd0)) begin
			res.status = sfhc_pkg::ST_LENGTH;
		end else if (total < need) begin
			res.status = sfhc_pkg::ST_SHORT;
		end else if (crc_d != rcrc_d) begin
			res.status = sfhc_pkg::ST_CRC;
		end else begin
			res.status = sfhc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			magic_ok_q <= 1'b1;
			cmd_q      <= '0;
			tid_q      <= '0;
			rcrc_q     <= '0;
			len_q      <= '0;
			crc_q      <= sfhc_pkg::CRC_INIT;
		end else if (accept) begin
			if (frame_last) begin
				pos_q      <= '0;
				magic_ok_q <= 1'b1;
				cmd_q      <= '0;
				tid_q      <= '0;
				rcrc_q     <= '0;
				len_q      <= '0;
				crc_q      <= sfhc_pkg::CRC_INIT;
			end else begin
				pos_q      <= pos_d;
				magic_ok_q <= magic_ok_d;
				cmd_q      <= cmd_d;
				tid_q      <= tid_d;
				rcrc_q     <= rcrc_d;
				len_q      <= len_d;
				crc_q      <= crc_d;
			end
		end
	end

endmodule

// File: hdl/sfhc_out.sv
// result register between the checker and the output stream
module sfhc_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  sfhc_pkg::res_t res_in,
	input  logic           out_ready,
	output logic           out_valid,
	output logic           in_ready,
	output sfhc_pkg::res_t res_out
);

	logic valid_q;

	assign out_valid = valid_q;
	assign in_ready  = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_out <= res_in;
		end
	end

endmodule

// File: dv/tb_top.sv
// self-checking testbench of the frame header crc checker: byte stream stimulus, prediction, compare
module tb_top;

	localparam int QUIET_LIMIT  = 3000;   // cycles with no transfer before the run is called hung
	localparam int HOLD_AT      = 1200;   // input bytes before the long result back-pressure
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_BYTES  = 300;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // [7:0] byte_value
	logic        s_tlast = 1'b0;   // frame_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;          // [2:0] status, [18:3] command,
	                               // [34:19] transaction_id, [50:35] payload_length
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	secure_frame_header_crc_checker dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// stimulus and expected results
	frame_byte_t     bytes_to_send[$];
	sfhc_pkg::res_t  status_due[$];
	frame_byte_t     next_byte;

	// frame tracker: own copy of the checker state and its registers
	sfhc_pkg::cfg_t trk_cfg = '0;
	logic [16:0] trk_pos = '0;
	logic        trk_magic_ok = 1'b1;
	logic [15:0] trk_cmd = '0;
	logic [15:0] trk_tid = '0;
	logic [15:0] trk_crc_rx = '0;
	logic [15:0] trk_len = '0;
	logic [15:0] trk_crc = sfhc_pkg::CRC_INIT;

	sfhc_pkg::cfg_t cur_cfg = '0;  // settings the frame builder works to
	logic        calm = 1'b0;      // no idling on either side
	logic        byte_taken = 1'b0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          quiet_cycles = 0;
	int          bytes_in = 0;
	int          bytes_queued = 0;
	int          frames_checked = 0;
	int          status_seen[5] = '{default: 0};
	int          mismatches = 0;
	int          settings = 0;
	sfhc_pkg::res_t want;
	logic [31:0] reg_want;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// reflected crc-16, poly 0xA001, one input bit per step
	function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ b[i]) begin
				c = (c >> 1) ^ sfhc_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// one received byte through the tracker; queues the status when it ends a frame
	task automatic absorb_frame_byte(input logic [7:0] b, input logic last);
		logic [16:0] p;
		logic [15:0] ct_len;
		int          total;
		int          need;
		sfhc_pkg::res_t r;
		p = trk_pos;
		ct_len = (trk_len >= sfhc_pkg::HEADER_BYTES) ?
			trk_len - 16'(sfhc_pkg::HEADER_BYTES) : 16'd0;
		case (p)
			sfhc_pkg::POS_MAGIC0: if (b != trk_cfg.magic_first) trk_magic_ok = 1'b0;
			sfhc_pkg::POS_MAGIC1: if (b != trk_cfg.magic_second) trk_magic_ok = 1'b0;
			sfhc_pkg::POS_CMD_HI: trk_cmd[15:8] = b;
			sfhc_pkg::POS_CMD_LO: trk_cmd[7:0] = b;
			sfhc_pkg::POS_TID_HI: trk_tid[15:8] = b;
			sfhc_pkg::POS_TID_LO: trk_tid[7:0] = b;
			sfhc_pkg::POS_CRC_HI: trk_crc_rx[15:8] = b;
			sfhc_pkg::POS_CRC_LO: trk_crc_rx[7:0] = b;
			sfhc_pkg::POS_LEN_HI: trk_len[15:8] = b;
			sfhc_pkg::POS_LEN_LO: trk_len[7:0] = b;
			default: begin
				// only ciphertext bytes feed the crc, the tag and trailing bytes do not
				if (p - 17'(sfhc_pkg::HEADER_BYTES) < {1'b0, ct_len})
					trk_crc = modbus_crc_step(trk_crc, b);
			end
		endcase
		if (trk_pos != sfhc_pkg::POS_MAX)
			trk_pos = trk_pos + 17'd1;
		if (last) begin
			total = int'(p) + 1;
			ct_len = (trk_len >= sfhc_pkg::HEADER_BYTES) ?
				trk_len - 16'(sfhc_pkg::HEADER_BYTES) : 16'd0;
			need = sfhc_pkg::HEADER_BYTES + int'(ct_len) +
				(trk_cfg.frame_mode ? 0 : sfhc_pkg::TAG_BYTES);
			// first failing check wins
			if (total < sfhc_pkg::HEADER_BYTES)
				r.status = sfhc_pkg::ST_SHORT;
			else if (!trk_magic_ok)
				r.status = sfhc_pkg::ST_MAGIC;
			else if (trk_len < sfhc_pkg::HEADER_BYTES)
				r.status = sfhc_pkg::ST_LENGTH;
			else if (trk_cfg.frame_mode &&
			         (ct_len == 0 || ct_len % sfhc_pkg::BLOCK_BYTES != 0))
				r.status = sfhc_pkg::ST_LENGTH;
			else if (total < need)
				r.status = sfhc_pkg::ST_SHORT;
			else if (trk_crc != trk_crc_rx)
				r.status = sfhc_pkg::ST_CRC;
			else
				r.status = sfhc_pkg::ST_OK;
			r.command = trk_cmd;
			r.transaction_id = trk_tid;
			r.payload_length = ct_len;
			status_due.push_back(r);
			trk_pos = '0;
			trk_magic_ok = 1'b1;
			trk_cmd = '0;
			trk_tid = '0;
			trk_crc_rx = '0;
			trk_len = '0;
			trk_crc = sfhc_pkg::CRC_INIT;
		end
	endtask

	// sender: a held byte stays until its transfer, then the next one or a gap
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !byte_taken)) begin
			if (bytes_to_send.size() != 0 &&
			    (calm || hold_left != 0 || $urandom_range(0, 99) >= 32)) begin
				next_byte = bytes_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_byte.value;
				s_tlast <= next_byte.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off so the checker backs up its input
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && bytes_in >= HOLD_AT) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (arst_n) begin
			m_tready <= calm || ($urandom_range(0, 99) >= 32);
		end
	end

	// monitor: tracks input transfers, compares result transfers and register reads
	always @(posedge clk) begin
		if (arst_n) begin
			byte_taken <= s_tvalid && s_tready;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;

			if (s_tvalid && s_tready) begin
				absorb_frame_byte(s_tdata, s_tlast);
				bytes_in <= bytes_in + 1;
			end

			if (m_tvalid && m_tready) begin
				if (status_due.size() == 0) begin
					report_mismatch($sformatf("result %h with no frame status due", m_tdata));
				end else begin
					want = status_due.pop_front();
					if (m_tdata[2:0] != want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							m_tdata[2:0], want.status));
					if (m_tdata[18:3] != want.command)
						report_mismatch($sformatf("command %h, want %h",
							m_tdata[18:3], want.command));
					if (m_tdata[34:19] != want.transaction_id)
						report_mismatch($sformatf("transaction id %h, want %h",
							m_tdata[34:19], want.transaction_id));
					if (m_tdata[50:35] != want.payload_length)
						report_mismatch($sformatf("payload length %0d, want %0d",
							m_tdata[50:35], want.payload_length));
				end
				frames_checked <= frames_checked + 1;
				if (m_tdata[2:0] <= 3'd4)
					status_seen[m_tdata[2:0]] <= status_seen[m_tdata[2:0]] + 1;
			end

			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						sfhc_pkg::REG_MODE:   trk_cfg.frame_mode = pwdata[0];
						sfhc_pkg::REG_MAGIC0: trk_cfg.magic_first = pwdata[7:0];
						sfhc_pkg::REG_MAGIC1: trk_cfg.magic_second = pwdata[7:0];
						default: ;  // no register there
					endcase
				end else begin
					case (paddr[3:2])
						sfhc_pkg::REG_MODE:   reg_want = {31'd0, trk_cfg.frame_mode};
						sfhc_pkg::REG_MAGIC0: reg_want = {24'd0, trk_cfg.magic_first};
						sfhc_pkg::REG_MAGIC1: reg_want = {24'd0, trk_cfg.magic_second};
						default:              reg_want = 32'd0;
					endcase
					if (prdata != reg_want)
						report_mismatch($sformatf("read at %h gave %h, want %h",
							paddr, prdata, reg_want));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("hung: no transfer for %0d cycles", QUIET_LIMIT);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// one register access: setup cycle, then access cycle
	task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// upper data bits are junk on purpose, the registers keep only their own width
	task automatic set_config(input logic mode, input logic [7:0] m0, input logic [7:0] m1);
		apb_access(1'b1, {sfhc_pkg::REG_MODE, 2'b00}, {31'($urandom), mode});
		apb_access(1'b1, {sfhc_pkg::REG_MAGIC0, 2'b00}, {24'($urandom), m0});
		apb_access(1'b1, {sfhc_pkg::REG_MAGIC1, 2'b00}, {24'($urandom), m1});
		apb_access(1'b0, {sfhc_pkg::REG_MODE, 2'b00}, '0);
		apb_access(1'b0, {sfhc_pkg::REG_MAGIC0, 2'b00}, '0);
		apb_access(1'b0, {sfhc_pkg::REG_MAGIC1, 2'b00}, '0);
		cur_cfg.frame_mode = mode;
		cur_cfg.magic_first = m0;
		cur_cfg.magic_second = m1;
		settings++;
	endtask

	// nothing pending, nothing in flight
	task automatic wait_idle();
		while (bytes_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// header, pay_n ciphertext bytes with their crc, tail_n more bytes, cut to cut bytes if 0 < cut < frame size
	task automatic queue_frame(input logic [7:0] m0, input logic [7:0] m1,
			input logic [15:0] cmd, input logic [15:0] tid, input logic [15:0] len,
			input int pay_n, input int tail_n, input bit crc_bad, input int cut);
		logic [7:0]  body[$];
		logic [7:0]  hdr[10];
		logic [7:0]  b;
		logic [15:0] crc;
		frame_byte_t fb;
		int          n;
		crc = sfhc_pkg::CRC_INIT;
		for (int i = 0; i < pay_n + tail_n; i++) begin
			b = 8'($urandom_range(0, 255));
			if (i < pay_n)
				crc = modbus_crc_step(crc, b);
			body.push_back(b);
		end
		if (crc_bad)
			crc = crc ^ (16'd1 << $urandom_range(0, 15));
		hdr = '{m0, m1, cmd[15:8], cmd[7:0], tid[15:8], tid[7:0],
			crc[15:8], crc[7:0], len[15:8], len[7:0]};
		for (int i = 9; i >= 0; i--)
			body.push_front(hdr[i]);
		n = body.size();
		if (cut > 0 && cut < n)
			n = cut;
		for (int i = 0; i < n; i++) begin
			fb.value = body[i];
			fb.last = (i == n - 1);
			bytes_to_send.push_back(fb);
		end
		bytes_queued += n;
	endtask

	// mostly well-formed frames for the current settings, the rest broken or noise
	task automatic queue_random_frame();
		int          kind;
		int          ct;
		int          tail;
		int          cut;
		int          n;
		bit          bad;
		logic [7:0]  m0;
		logic [7:0]  m1;
		logic [15:0] len;
		frame_byte_t fb;
		m0 = cur_cfg.magic_first;
		m1 = cur_cfg.magic_second;
		ct = cur_cfg.frame_mode ? sfhc_pkg::BLOCK_BYTES * $urandom_range(1, 2) :
			$urandom_range(0, 24);
		tail = cur_cfg.frame_mode ? 0 : sfhc_pkg::TAG_BYTES;
		if ($urandom_range(0, 4) == 0)
			tail += $urandom_range(1, 4);
		bad = 1'b0;
		cut = 0;
		kind = $urandom_range(0, 99);
		if (kind >= 60 && kind < 68) begin
			bad = 1'b1;
		end else if (kind >= 68 && kind < 74) begin
			if ($urandom_range(0, 1))
				m0 = m0 ^ 8'($urandom_range(1, 255));
			else
				m1 = m1 ^ 8'($urandom_range(1, 255));
		end else if (kind >= 74 && kind < 80) begin
			cut = $urandom_range(1, sfhc_pkg::HEADER_BYTES - 1);
		end else if (kind >= 80 && kind < 86) begin
			cut = $urandom_range(sfhc_pkg::HEADER_BYTES, sfhc_pkg::HEADER_BYTES + ct + tail - 1);
		end else if (kind >= 86 && kind < 91 && cur_cfg.frame_mode) begin
			// ciphertext empty or not a whole number of blocks
			ct = $urandom_range(0, 40);
			if (ct != 0 && ct % sfhc_pkg::BLOCK_BYTES == 0)
				ct++;
		end
		len = 16'(sfhc_pkg::HEADER_BYTES + ct);
		if (kind >= 86 && kind < 91 && !cur_cfg.frame_mode)
			len = 16'($urandom_range(0, sfhc_pkg::HEADER_BYTES - 1));
		if (kind < 91) begin
			queue_frame(m0, m1, pick16(), pick16(), len, ct, tail, bad, cut);
		end else begin
			n = $urandom_range(1, 40);
			for (int i = 0; i < n; i++) begin
				fb.value = 8'($urandom_range(0, 255));
				fb.last = (i == n - 1) || ($urandom_range(0, 7) == 0);
				bytes_to_send.push_back(fb);
			end
			bytes_queued += n;
		end
	endtask

	initial begin
		int         start;
		logic [7:0] ma;
		logic [7:0] mb;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames under reset settings: tagged mode, magic 00 00
		queue_frame(8'h00, 8'h00, 16'hFFFF, 16'h0000, 16'd10, 0, sfhc_pkg::TAG_BYTES, 1'b0, 0);
		queue_frame(8'h00, 8'h00, 16'h1234, 16'h5678, 16'd0, 0, 0, 1'b0, 0);      // length 0
		queue_frame(8'h00, 8'h00, 16'hABCD, 16'h0102, 16'd9, 0, sfhc_pkg::TAG_BYTES, 1'b0, 0);
		queue_frame(8'h00, 8'h00, 16'h1111, 16'h2222, 16'd12, 2, sfhc_pkg::TAG_BYTES, 1'b0, 1);
		// short header beats bad magic; half-received fields read with zeros
		queue_frame(8'h5A, 8'h00, 16'hBEEF, 16'hCAFE, 16'd12, 2, sfhc_pkg::TAG_BYTES, 1'b0, 9);
		queue_frame(8'h00, 8'h00, 16'hBEEF, 16'hCAFE, 16'd12, 2, sfhc_pkg::TAG_BYTES, 1'b0, 5);
		queue_frame(8'h00, 8'hA5, 16'h0F0F, 16'hF0F0, 16'd12, 2, sfhc_pkg::TAG_BYTES, 1'b0, 0);
		// payload plus tag cut short
		queue_frame(8'h00, 8'h00, 16'h0001, 16'h0002, 16'd15, 5, 3, 1'b0, 0);
		queue_frame(8'h00, 8'h00, 16'h7FFF, 16'h8000, 16'd18, 8, sfhc_pkg::TAG_BYTES, 1'b1, 0);
		// trailing bytes after the tag are ignored
		queue_frame(8'h00, 8'h00, 16'h4242, 16'h2424, 16'd13, 3, sfhc_pkg::TAG_BYTES + 5,
			1'b0, 0);
		wait_idle();
		apb_access(1'b1, 4'hC, $urandom);  // no register at this address

		// directed frames in block-aligned mode with magic FF FF
		set_config(1'b1, 8'hFF, 8'hFF);
		queue_frame(8'hFF, 8'hFF, 16'h0000, 16'hFFFF, 16'd10, 0, 0, 1'b0, 0);    // no ciphertext
		queue_frame(8'hFF, 8'hFF, 16'h0101, 16'h0202, 16'd25, 15, 0, 1'b0, 0);
		queue_frame(8'hFF, 8'hFF, 16'h0000, 16'hFFFF, 16'd26, 16, 0, 1'b0, 0);
		queue_frame(8'hFF, 8'hFF, 16'h3333, 16'h4444, 16'd42, 32, 0, 1'b1, 0);
		queue_frame(8'hFF, 8'hFF, 16'h5555, 16'h6666, 16'd26, 16, 0, 1'b0, 20);
		wait_idle();

		// random frames over several settings; one phase runs with no idling at all
		for (int ph = 0; ph < 5; ph++) begin
			ma = 8'($urandom);
			mb = 8'($urandom);
			case (ph)
				0: set_config(1'b0, ma, mb);
				1: set_config(1'b1, ma, mb);
				3: set_config(1'b0, 8'hFF, 8'h00);
				4: set_config(1'b1, 8'h00, 8'hFF);
				default: set_config(1'b0, 8'h00, 8'h00);
			endcase
			calm = (ph == 2);
			start = bytes_queued;
			while (bytes_queued - start < PHASE_BYTES)
				queue_random_frame();
			wait_idle();
		end
		calm = 1'b0;
		repeat (8) @(posedge clk);

		if (status_due.size() != 0)
			report_mismatch($sformatf("%0d frame statuses never came", status_due.size()));
		$display("checked %0d frames from %0d bytes: ok %0d, short %0d, magic %0d, length %0d, crc %0d",
			frames_checked, bytes_in, status_seen[0], status_seen[1], status_seen[2],
			status_seen[3], status_seen[4]);
		$display("%0d register settings, one long result hold-off, %0d mismatches",
			settings, mismatches);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// File: secure_frame_header_crc_checker.f
hdl/sfhc_pkg.sv
hdl/sfhc_frame.sv
hdl/sfhc_out.sv
hdl/secure_frame_header_crc_checker.sv
dv/tb_top.sv
